/* rtl/core/nfps_pkg.sv */
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared types and constants for the fixed-point Neumann solver.
// ----------------------------------------------------------------------------
`default_nettype none
package nfps_pkg;
  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned INT_BITS        = 8;
  localparam int unsigned ADDR_W          = 4;

  localparam logic [1:0] KIND_MATRIX = 2'd0;
  localparam logic [1:0] KIND_SOURCE = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam logic [1:0] REG_SIZE     = 2'd0;
  localparam logic [1:0] REG_EPSILON  = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_MAXITER  = 2'd3;

  localparam logic [6:0]  SIZE_RST     = 7'd64;
  localparam logic [30:0] EPSILON_RST  = 31'd1678;
  localparam logic [7:0]  INTERVAL_RST = 8'd10;
  localparam logic [15:0] MAXITER_RST  = 16'd10000;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic clear;   // start a new row: acc <- source
    logic mac;     // accumulate one product
    logic commit;  // row done: saturate into current
    logic advance; // iteration done: previous <- current
    logic init;    // start of solve: previous <- source
  } cell_ctrl_t;
endpackage
`default_nettype wire

/* rtl/core/nfps_if.sv */
// ----------------------------------------------------------------------------
// nfps_in_if / nfps_out_if
// Valid/ready channels of the solver.
// ----------------------------------------------------------------------------
`default_nettype none
interface nfps_in_if ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] value;
  modport source(output valid, kind, row, col, value, input ready);
  modport sink(input valid, kind, row, col, value, output ready);
endinterface

interface nfps_out_if ();
  logic               valid;
  logic               ready;
  logic [5:0]         index;
  logic signed [31:0] solution;
  logic [15:0]        iterations;
  logic               converged;
  logic               last;
  modport source(output valid, index, solution, iterations, converged, last,
                 input ready);
  modport sink(input valid, index, solution, iterations, converged, last,
               output ready);
endinterface
`default_nettype wire

/* rtl/core/nfps_cell.sv */
// ----------------------------------------------------------------------------
// nfps_cell
// One row of the solver: holds its source, previous and current element,
// accumulates one product per cycle, and shifts its previous element on.
// ----------------------------------------------------------------------------
`default_nettype none
module nfps_cell
  import nfps_pkg::*;
#(
  parameter int unsigned VW = 32
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 src_we,
  input  wire logic signed [VW-1:0] src_wdata,
  input  wire logic signed [VW-1:0] kval,      // matrix entry (row, col)
  input  wire logic signed [VW-1:0] x_in,      // previous element arriving
  output logic signed [VW-1:0]      x_out,     // previous element leaving
  output logic signed [VW-1:0]      cur,
  output logic signed [VW-1:0]      prev
);
  localparam int unsigned FB = VW - INT_BITS;
  // Room for up to 64 products plus the source without wrapping.
  localparam int unsigned AW = VW + INT_BITS + 8;

  logic signed [VW-1:0]   src_r, prev_r, cur_r, rot_r;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic signed [2*VW-1:0] prod;
  logic signed [AW-1:0]   term;
  logic signed [AW-1:0]   vmax, vmin;

  assign prod = kval * x_in;
  // Floor drop of the fraction bits; product of two VW values fits after shift.
  assign term = AW'(prod >>> FB);
  assign vmax = AW'({1'b0, {(VW-1){1'b1}}});
  assign vmin = ~vmax;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) acc_nxt = AW'(src_r);
    else if (ctrl.mac) acc_nxt = acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (src_we) src_r <= src_wdata;
    acc_r <= acc_nxt;
    if (ctrl.commit) begin
      if (acc_r > vmax) cur_r <= vmax[VW-1:0];
      else if (acc_r < vmin) cur_r <= vmin[VW-1:0];
      else cur_r <= acc_r[VW-1:0];
    end
    if (ctrl.init) begin
      prev_r <= src_r;
      rot_r  <= src_r;
    end else if (ctrl.advance) begin
      prev_r <= cur_r;
      rot_r  <= cur_r;
    end else if (ctrl.mac) begin
      rot_r <= x_in;
    end
  end

  assign x_out = rot_r;
  assign cur   = cur_r;
  assign prev  = prev_r;
endmodule
`default_nettype wire

/* rtl/core/neumann_fixed_point_solver.sv */
// ----------------------------------------------------------------------------
// neumann_fixed_point_solver
// Solves x = K*x + f by fixed-point iteration on a ring of row cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  in_     | in  | kind, row, col, value                    | valid/ready
//  out_    | out | index, solution, iterations, converged, last | valid/ready
//  cfg_    | in  | APB write/read of four registers          | pready = 1
//
//  A solve spends an init step, then per iteration for n points n products,
//  one commit and one advance (one product per cell per cycle, set by the
//  ring that rotates the previous iterate past the cells), plus a pass over
//  the n cells for each convergence check, and then emits the results; the
//  final iteration skips the advance. The matrix sits in one memory per row
//  read once per cycle. Reset is synchronous; stores need no clear.
//  Input is held off while a solve runs; results stall on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module neumann_fixed_point_solver
  import nfps_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  nfps_in_if.sink                in_ch,
  nfps_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  localparam int unsigned N  = MAX_POINTS;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned IW = $clog2(N);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ROW, S_COMMIT, S_CHECK,
                            S_ADV, S_OUT} state_t;

  // ---------------- configuration registers
  logic [6:0]  size_r;
  logic [30:0] eps_r;
  logic [7:0]  ival_r;
  logic [15:0] maxit_r;
  logic        cfg_we;
  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RST;
      eps_r   <= EPSILON_RST;
      ival_r  <= INTERVAL_RST;
      maxit_r <= MAXITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_paddr[3:2])
        REG_SIZE:     size_r  <= cfg_pwdata[6:0];
        REG_EPSILON:  eps_r   <= cfg_pwdata[30:0];
        REG_INTERVAL: ival_r  <= cfg_pwdata[7:0];
        REG_MAXITER:  maxit_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SIZE:     cfg_prdata = {25'd0, size_r};
      REG_EPSILON:  cfg_prdata = {1'b0, eps_r};
      REG_INTERVAL: cfg_prdata = {24'd0, ival_r};
      REG_MAXITER:  cfg_prdata = {16'd0, maxit_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- effective size (n-1 in IW bits)
  logic [IW-1:0] nm1;
  always_comb begin
    if (size_r == 7'd0) nm1 = '0;
    else if (32'(size_r) > N) nm1 = IW'(N - 1);
    else nm1 = IW'(size_r - 7'd1);
  end

  // ---------------- input saturation to VW bits
  logic signed [VW-1:0] in_sat;
  always_comb begin
    if (VW >= 32) in_sat = VW'(in_ch.value);
    else if (in_ch.value > $signed(33'({1'b0, {(VW-1){1'b1}}})))
      in_sat = {1'b0, {(VW-1){1'b1}}};
    else if (in_ch.value < -$signed(33'({1'b0, {(VW-1){1'b1}}})) - 33'sd1)
      in_sat = {1'b1, {(VW-1){1'b0}}};
    else in_sat = VW'(in_ch.value);
  end

  // ---------------- sequencer registers
  state_t        state_r;
  logic [IW-1:0] col_r;   // product step within a row, also check pointer
  logic [15:0]   iter_r;
  logic [7:0]    icnt_r;  // iterations since last check
  logic          conv_r, ok_r;
  logic          out_v_r;
  logic [IW-1:0] oidx_r;

  logic in_fire, out_fire, busy;
  assign busy     = (state_r != S_IDLE);
  assign in_ch.ready = !busy;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // Memory address runs one step ahead of the products (registered read).
  logic [IW-1:0] col_nx;
  always_comb begin
    col_nx = '0;
    if (state_r == S_ROW) col_nx = col_r + 1'b1;
  end

  // ---------------- ring of cells
  cell_ctrl_t            ctrl;
  logic signed [VW-1:0]  xo   [N];
  logic signed [VW-1:0]  cur  [N];
  logic signed [VW-1:0]  prv  [N];
  logic signed [VW-1:0]  kq   [N];

  always_comb begin
    ctrl = '0;
    ctrl.init    = (state_r == S_INIT);
    ctrl.clear   = (state_r == S_INIT) || (state_r == S_ADV);
    ctrl.mac     = (state_r == S_ROW);
    ctrl.commit  = (state_r == S_COMMIT);
    ctrl.advance = (state_r == S_ADV);
  end

  for (genvar g = 0; g < N; g++) begin : g_row
    logic signed [VW-1:0] mem [N];
    logic [IW-1:0] ra;
    logic [IW:0] sum;
    logic signed [VW-1:0] xin;
    // Cell g sees previous element (g + step) mod n at each step; ring is
    // closed at n-1 so rotation stays within the points in use.
    assign sum = {1'b0, IW'(g)} + {1'b0, col_nx};
    assign ra  = (sum > {1'b0, nm1}) ? IW'(sum - {1'b0, nm1} - 1'b1) : sum[IW-1:0];
    always_ff @(posedge clk) begin
      if (in_fire && in_ch.kind == KIND_MATRIX && 32'(in_ch.row) == g
          && 32'(in_ch.col) < N)
        mem[in_ch.col[IW-1:0]] <= in_sat;
      kq[g] <= mem[ra];
    end
    assign xin = (IW'(g) == nm1) ? xo[0] : xo[(g + 1) % N];
    nfps_cell #(.VW(VW)) u_cell (
      .clk(clk), .ctrl(ctrl),
      .src_we(in_fire && in_ch.kind == KIND_SOURCE && 32'(in_ch.row) == g),
      .src_wdata(in_sat), .kval(kq[g]),
      .x_in(col_r == '0 ? xo[g] : xin),
      .x_out(xo[g]), .cur(cur[g]), .prev(prv[g])
    );
  end

  // First product uses x_in = own rotation register (step 0 = own index).
  // Rotation shifts once per mac from step 1 on; on step 0 cell keeps its own.

  // ---------------- convergence check over cells, one per cycle
  logic signed [VW:0] diff;
  logic [VW:0]        adiff;
  assign diff  = {cur[col_r][VW-1], cur[col_r]} - {prv[col_r][VW-1], prv[col_r]};
  assign adiff = diff[VW] ? (VW+1)'(-diff) : diff;

  logic [7:0] ival_e;
  assign ival_e = (ival_r == 8'd0) ? 8'd1 : ival_r;

  logic signed [VW-1:0] osel;
  assign osel = cur[oidx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      iter_r  <= '0;
      icnt_r  <= '0;
      conv_r  <= 1'b0;
      ok_r    <= 1'b0;
      out_v_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.kind == KIND_START) begin
            state_r <= S_INIT;
            iter_r  <= '0;
            icnt_r  <= '0;
            col_r   <= '0;
          end
        end
        S_INIT: state_r <= S_ROW;
        S_ROW: begin
          if (col_r == nm1) begin
            state_r <= S_COMMIT;
            col_r   <= '0;
          end else col_r <= col_r + 1'b1;
        end
        S_COMMIT: begin
          iter_r <= iter_r + 16'd1;
          ok_r   <= 1'b1;
          col_r  <= '0;
          if (icnt_r + 8'd1 >= ival_e) begin
            icnt_r  <= '0;
            state_r <= S_CHECK;
          end else begin
            icnt_r <= icnt_r + 8'd1;
            if (iter_r + 16'd1 >= maxit_r) begin
              conv_r <= 1'b0; state_r <= S_OUT; oidx_r <= '0; out_v_r <= 1'b1;
            end else state_r <= S_ADV;
          end
        end
        S_CHECK: begin
          if (adiff >= (VW+1)'(eps_r)) ok_r <= 1'b0;
          if (col_r == nm1) begin
            col_r <= '0;
            if (ok_r && !(adiff >= (VW+1)'(eps_r))) begin
              conv_r <= 1'b1; state_r <= S_OUT; oidx_r <= '0; out_v_r <= 1'b1;
            end else if (iter_r >= maxit_r) begin
              conv_r <= 1'b0; state_r <= S_OUT; oidx_r <= '0; out_v_r <= 1'b1;
            end else state_r <= S_ADV;
          end else col_r <= col_r + 1'b1;
        end
        S_ADV: state_r <= S_ROW;
        S_OUT: begin
          if (out_fire) begin
            if (oidx_r == nm1) begin
              out_v_r <= 1'b0;
              state_r <= S_IDLE;
            end else oidx_r <= oidx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Solution saturated to 32-bit signed when values are wider.
  always_comb begin
    if (VW <= 32) out_ch.solution = 32'(osel);
    else if (osel > $signed(VW'(32'h7fffffff))) out_ch.solution = 32'h7fffffff;
    else if (osel < -$signed(VW'(32'h7fffffff)) - 1) out_ch.solution = 32'h80000000;
    else out_ch.solution = 32'(osel);
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.index      = 6'(oidx_r);
  assign out_ch.iterations = iter_r;
  assign out_ch.converged  = conv_r;
  assign out_ch.last       = (oidx_r == nm1);
endmodule
`default_nettype wire

/* rtl/core/nfps_checker.sv */
// ----------------------------------------------------------------------------
// nfps_checker
// Port-level checks on the solver's result stream.
// ----------------------------------------------------------------------------
`default_nettype none
module nfps_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [5:0] out_index,
  input wire logic [15:0] out_iterations
);
  // Hold off input while results are pending.
  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during results");
  // Advance index by one after a non-final result.
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_index == $past(out_index) + 6'd1)
    else $error("index skipped");
  // Drop valid after the final result.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid) else $error("extra result");
  // Hold the iteration count across a burst.
  a_it: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) |-> $stable(out_iterations)) else $error("count moved");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iterations != 16'd0) else $error("zero iterations");
endmodule

bind neumann_fixed_point_solver nfps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
  .out_index(out_ch.index), .out_iterations(out_ch.iterations)
);
`default_nettype wire

/* dv/neumann_fixed_point_solver_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neumann_fixed_point_solver_test
// Self-checking bench for the fixed-point Neumann solver. Matrix and source
// loads are driven on the input channel and solves are started. A Q8.24
// predictor runs each solve at the moment the start transaction is accepted,
// and every result transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module neumann_fixed_point_solver_test;
  import nfps_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd3;  // unused code, block drops it
  localparam int         FRAC        = 24;
  localparam int         IDLE_LIMIT  = 60000;
  localparam int         RANDOM_ITEMS = 60;

  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] solution;
    logic [15:0]        iterations;
    logic               converged;
    logic               last;
  } sol_elem_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  nfps_in_if  in_ch ();
  nfps_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  neumann_fixed_point_solver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predictor state: a shadow of the stores and of the registers.
  logic signed [31:0] kernel_shadow [64][64];
  logic signed [31:0] source_shadow [64];
  logic [6:0]         size_reg;
  logic [30:0]        eps_reg;
  logic [7:0]         interval_reg;
  logic [15:0]        maxiter_reg;

  sol_elem_t expected_elems[$];
  int        mismatches;
  int        idle_cycles;
  int        random_items;

  // Receiver control: a request for one long hold-off.
  bit pressure_req;
  int hold_left;
  int burst_left;
  int sender_burst;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Run one solve over the shadow stores and queue its solution elements.
  task automatic predict_solve();
    longint prev [64];
    longint cur [64];
    longint acc;
    longint diff;
    int     n;
    int     interval;
    int     iter;
    bit     conv;
    bit     ok;
    sol_elem_t e;
    n        = (size_reg == 0) ? 1 : (size_reg > 64) ? 64 : int'(size_reg);
    interval = (interval_reg == 0) ? 1 : int'(interval_reg);
    iter     = 0;
    conv     = 1'b0;
    for (int i = 0; i < n; i++) prev[i] = source_shadow[i];
    forever begin
      for (int i = 0; i < n; i++) begin
        acc = source_shadow[i];
        // exact product, floored to the fraction width
        for (int j = 0; j < n; j++)
          acc += (longint'(kernel_shadow[i][j]) * prev[j]) >>> FRAC;
        cur[i] = sat32(acc);
      end
      iter++;
      if (iter % interval == 0) begin
        ok = 1'b1;
        for (int i = 0; i < n; i++) begin
          diff = cur[i] - prev[i];
          if (diff < 0) diff = -diff;
          if (diff >= longint'(eps_reg)) ok = 1'b0;
        end
        if (ok) begin
          conv = 1'b1;
          break;
        end
      end
      if (iter >= int'(maxiter_reg)) break;
      for (int i = 0; i < n; i++) prev[i] = cur[i];
    end
    for (int i = 0; i < n; i++) begin
      e.index      = 6'(i);
      e.solution   = 32'(cur[i]);
      e.iterations = 16'(iter);
      e.converged  = conv;
      e.last       = (i == n - 1);
      expected_elems.push_back(e);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Send one transaction, update the predictor when it is accepted.
  task automatic send_item(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                           logic signed [31:0] value);
    int gap;
    int r;
    gap = 0;
    if (sender_burst > 0) begin
      sender_burst--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) sender_burst = $urandom_range(20, 60);
      else if (r < 65) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.row   <= row;
    in_ch.col   <= col;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    case (kind)
      KIND_MATRIX: kernel_shadow[row][col] = value;
      KIND_SOURCE: source_shadow[row] = value;
      KIND_START:  predict_solve();
      default: ;
    endcase
  endtask

  task automatic in_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let trailing loads drain.
  task automatic drain();
    in_idle();
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [1:0] reg_idx, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({reg_idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (reg_idx)
      REG_SIZE:     size_reg     = data[6:0];
      REG_EPSILON:  eps_reg      = data[30:0];
      REG_INTERVAL: interval_reg = data[7:0];
      REG_MAXITER:  maxiter_reg  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] sz, logic [31:0] eps, logic [31:0] ivl,
                           logic [31:0] cap);
    cfg_write(REG_SIZE, sz);
    cfg_write(REG_EPSILON, eps);
    cfg_write(REG_INTERVAL, ivl);
    cfg_write(REG_MAXITER, cap);
  endtask

  // Small kernel entry: keeps the row sum of |K| at most one quarter.
  function automatic logic signed [31:0] small_entry(int n);
    int m;
    m = (1 << FRAC) / (4 * n);
    return 32'($signed($urandom_range(0, 2 * m)) - m);
  endfunction

  // Load a full n x n kernel and n sources, mixed with dropped transactions.
  task automatic load_problem(int n, bit wild);
    logic signed [31:0] v;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        v = wild ? 32'($urandom) : small_entry(n);
        send_item(KIND_MATRIX, 6'(i), 6'(j), v);
        if ($urandom_range(0, 9) == 0)
          send_item(KIND_NONE, 6'($urandom), 6'($urandom), 32'($urandom));
      end
      v = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 26));
      send_item(KIND_SOURCE, 6'(i), 6'($urandom), v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Extremes of values and registers on a tiny problem.
  task automatic test_directed();
    send_item(KIND_MATRIX, 6'd0, 6'd0, 32'sh7FFFFFFF);
    send_item(KIND_MATRIX, 6'd0, 6'd1, 32'sh80000000);
    send_item(KIND_MATRIX, 6'd1, 6'd0, 32'sh00000000);
    send_item(KIND_MATRIX, 6'd1, 6'd1, 32'sh01000000);
    send_item(KIND_SOURCE, 6'd0, 6'd63, 32'sh80000000);
    send_item(KIND_SOURCE, 6'd1, 6'd0, 32'sh7FFFFFFF);
    send_item(KIND_NONE, 6'd63, 6'd63, 32'shFFFFFFFF);
    drain();
    // zero tolerance, interval zero, cap zero: exactly one iteration
    configure(32'd2, 32'd0, 32'd0, 32'd0);
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    drain();
    // saturating run that stops on the cap
    configure(32'd2, 32'd0, 32'd3, 32'd5);
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    drain();
    // size zero acts as one; loosest tolerance converges at the first check
    send_item(KIND_MATRIX, 6'd0, 6'd0, 32'sd0);
    send_item(KIND_SOURCE, 6'd0, 6'd0, 32'sh12345678);
    drain();
    configure(32'hFFFFFF80, 32'hFFFFFFFF, 32'd255, 32'd65535);
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    drain();
  endtask

  // Wide kernel values that saturate, solved twice from the same stores.
  task automatic test_wide_values();
    configure(32'd6, 32'd1678, 32'd1, 32'd3);
    load_problem(6, 1'b1);
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    drain();
    configure(32'd6, 32'd1678, 32'd2, 32'd4);
    send_item(KIND_START, 6'h3F, 6'h3F, 32'shFFFFFFFF);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering transactions.
  task automatic test_backpressure();
    configure(32'd4, 32'd100, 32'd1, 32'd20);
    load_problem(4, 1'b0);
    pressure_req = 1'b1;
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    for (int k = 0; k < 6; k++)
      send_item(KIND_SOURCE, 6'($urandom_range(0, 3)), 6'd0, 32'($urandom_range(0, 1 << 25)));
    send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
    drain();
  endtask

  // Random problems under random settings.
  task automatic test_random();
    int  n;
    bit  wild;
    while (random_items < RANDOM_ITEMS) begin
      n    = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      wild = ($urandom_range(0, 4) == 0);
      configure(32'(n),
                ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 4000)),
                32'($urandom_range(0, 12)),
                32'($urandom_range(1, wild ? 20 : 150)));
      load_problem(n, wild);
      send_item(KIND_START, 6'($urandom), 6'($urandom), 32'($urandom));
      random_items += n * n + n + 1;
      if ($urandom_range(0, 3) == 0) begin
        send_item(KIND_START, 6'd0, 6'd0, 32'sd0);
        random_items++;
      end
      drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, bursts without stalls, one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (pressure_req) begin
      pressure_req = 1'b0;
      hold_left    = 400;
      out_ch.ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        burst_left = $urandom_range(30, 80);
        out_ch.ready <= 1'b1;
      end else if (r < 65) begin
        out_ch.ready <= 1'b1;
      end else if (r < 96) begin
        hold_left = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        hold_left = $urandom_range(10, 40);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each transaction with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sol_elem_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result index=%0d solution=%0d",
                   out_ch.index, out_ch.solution);
      end else begin
        e = expected_elems.pop_front();
        if (out_ch.index !== e.index || out_ch.solution !== e.solution ||
            out_ch.iterations !== e.iterations || out_ch.converged !== e.converged ||
            out_ch.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: exp idx=%0d sol=%0d it=%0d conv=%0b last=%0b",
                     e.index, e.solution, e.iterations, e.converged, e.last);
            $display("       got idx=%0d sol=%0d it=%0d conv=%0b last=%0b",
                     out_ch.index, out_ch.solution, out_ch.iterations,
                     out_ch.converged, out_ch.last);
          end
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_NONE;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    in_ch.value  <= '0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    size_reg     = SIZE_RST;
    eps_reg      = EPSILON_RST;
    interval_reg = INTERVAL_RST;
    maxiter_reg  = MAXITER_RST;
    mismatches   = 0;
    idle_cycles  = 0;
    random_items = 0;
    pressure_req = 1'b0;
    hold_left    = 0;
    burst_left   = 0;
    sender_burst = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_wide_values();
    test_backpressure();
    test_random();

    // all stimulus accepted: wait out the tail, the watchdog bounds this
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_elems.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
